@@ hw/rtl/rolling_key_byte_decryptor_core_assert.svh @@
`ifndef ROLLING_KEY_BYTE_DECRYPTOR_CORE_ASSERT_SVH
`define ROLLING_KEY_BYTE_DECRYPTOR_CORE_ASSERT_SVH
// ---------------------------------------------------------------------------
// Assertion macros for the rolling key byte decryptor
// Each macro samples on i_clk and is disabled while i_rst_n is low.
// ---------------------------------------------------------------------------

// The consequent must hold in the cycle after the antecedent.
`define RKBD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("rkbd next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define RKBD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("rkbd same-cycle check failed");

`endif

@@ hw/rtl/rkbd_pkg.sv @@
// ---------------------------------------------------------------------------
// rkbd_pkg
// Types, codes and key schedule functions shared by the decryptor modules.
// ---------------------------------------------------------------------------
package rkbd_pkg;

    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_ADDR_W = 6;
    localparam int unsigned KEY_W      = 128;
    localparam int unsigned KN_W       = 7;
    localparam int unsigned POS_W      = 4;
    localparam int unsigned COUNT_W    = 16;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned IN_DATA_W  = BYTE_W + COUNT_W;

    localparam logic [2:0] REG_KEY_A_LO  = 3'd0;
    localparam logic [2:0] REG_KEY_A_HI  = 3'd1;
    localparam logic [2:0] REG_KEY_B_LO  = 3'd2;
    localparam logic [2:0] REG_KEY_B_HI  = 3'd3;
    localparam logic [2:0] REG_START_KN  = 3'd4;

    localparam logic [POS_W-1:0] POS_B_START = 4'd8;

    typedef enum logic [1:0] {
        ACT_START   = 2'd0,
        ACT_DECRYPT = 2'd1,
        ACT_SKIP    = 2'd2
    } t_action;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SKIP = 1'b1
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0] key_a;
        logic [KEY_W-1:0] key_b;
        logic [KN_W-1:0]  start_kn;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic decrypt;
        logic skip_first;
        logic skip_step;
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic count_le_one;
        logic remain_one;
    } t_dp_sts;

    typedef struct packed {
        logic [KN_W-1:0]  kn;
        logic [POS_W-1:0] pos_a;
        logic [POS_W-1:0] pos_b;
        logic             swap;
    } t_sched;

    // Since 8 is 1 modulo 7, folding the octal digits keeps the residue.
    function automatic logic [2:0] mod7(input logic [KN_W-1:0] x);
        logic [4:0] s1;
        logic [3:0] s2;
        s1 = {1'b0, x[6:3]} + {2'b0, x[2:0]};
        s2 = {2'b0, s1[4:3]} + {1'b0, s1[2:0]};
        if (s2 >= 4'd7) begin
            s2 = s2 - 4'd7;
        end
        return s2[2:0];
    endfunction

    // x mod 12 is four times (x / 4) mod 3 plus the two low bits.
    function automatic logic [3:0] mod12(input logic [KN_W-1:0] x);
        logic [3:0] y1;
        logic [2:0] y2;
        y1 = {1'b0, x[6:4]} + {2'b0, x[3:2]};
        y2 = {1'b0, y1[3:2]} + {1'b0, y1[1:0]};
        if (y2 >= 3'd3) begin
            y2 = y2 - 3'd3;
        end
        return {y2[1:0], x[1:0]};
    endfunction

    // One step of the position wrap schedule.
    function automatic t_sched sched_step(input t_sched s);
        t_sched          r;
        logic [4:0]      a;
        logic [4:0]      b;
        logic [KN_W-1:0] kn;
        r  = s;
        a  = {1'b0, s.pos_a} + 5'd1;
        b  = {1'b0, s.pos_b} + 5'd1;
        kn = s.kn + 7'd2;
        if (!a[4]) begin
            if (b > 5'd12) begin
                b      = 5'd0;
                r.swap = ~s.swap;
            end
        end else if (b <= 5'd8) begin
            a      = 5'd0;
            r.swap = ~s.swap;
        end else begin
            r.kn = kn;
            if (s.swap) begin
                r.swap = 1'b0;
                a      = {2'b0, mod7(kn)};
                b      = {1'b0, mod12(kn)} + 5'd2;
            end else begin
                r.swap = 1'b1;
                a      = {1'b0, mod12(kn)} + 5'd3;
                b      = {2'b0, mod7(kn)};
            end
        end
        r.pos_a = a[3:0];
        r.pos_b = b[3:0];
        return r;
    endfunction

endpackage

@@ hw/rtl/rkbd_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// rkbd_cfg_regs
// APB register file holding both keys and the start key number.
// ---------------------------------------------------------------------------
module rkbd_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rkbd_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [rkbd_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [rkbd_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready,
    output rkbd_pkg::t_cfg                     o_cfg
);
    import rkbd_pkg::*;

    logic [CFG_DATA_W-1:0] r_key_a_lo;
    logic [CFG_DATA_W-1:0] r_key_a_hi;
    logic [CFG_DATA_W-1:0] r_key_b_lo;
    logic [CFG_DATA_W-1:0] r_key_b_hi;
    logic [KN_W-1:0]       r_start_kn;
    logic                  wr_en;
    logic [2:0]            reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_a_lo <= '0;
            r_key_a_hi <= '0;
            r_key_b_lo <= '0;
            r_key_b_hi <= '0;
            r_start_kn <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_KEY_A_LO: r_key_a_lo <= pwdata;
                REG_KEY_A_HI: r_key_a_hi <= pwdata;
                REG_KEY_B_LO: r_key_b_lo <= pwdata;
                REG_KEY_B_HI: r_key_b_hi <= pwdata;
                REG_START_KN: r_start_kn <= pwdata[KN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_KEY_A_LO: prdata = r_key_a_lo;
            REG_KEY_A_HI: prdata = r_key_a_hi;
            REG_KEY_B_LO: prdata = r_key_b_lo;
            REG_KEY_B_HI: prdata = r_key_b_hi;
            REG_START_KN: prdata = {{(CFG_DATA_W-KN_W){1'b0}}, r_start_kn};
            default:      prdata = '0;
        endcase
    end

    assign o_cfg.key_a    = {r_key_a_hi, r_key_a_lo};
    assign o_cfg.key_b    = {r_key_b_hi, r_key_b_lo};
    assign o_cfg.start_kn = r_start_kn;

endmodule

@@ hw/rtl/rkbd_datapath.sv @@
// ---------------------------------------------------------------------------
// rkbd_datapath
// Key schedule state, skip counter and the byte decrypt path.
// ---------------------------------------------------------------------------
module rkbd_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rkbd_pkg::t_dp_cmd                 i_cmd,
    input  rkbd_pkg::t_cfg                    i_cfg,
    input  logic [rkbd_pkg::IN_DATA_W-1:0]    i_data,
    output rkbd_pkg::t_dp_sts                 o_sts,
    output logic [rkbd_pkg::BYTE_W-1:0]       o_plain
);
    import rkbd_pkg::*;

    t_sched              r_sched;
    t_sched              n_sched;
    t_sched              stepped;
    logic [COUNT_W-1:0]  r_cnt;
    logic [COUNT_W-1:0]  n_cnt;
    logic [BYTE_W-1:0]   r_plain;
    logic [BYTE_W-1:0]   cipher;
    logic [COUNT_W-1:0]  count;
    logic [BYTE_W-1:0]   key_b_byte;
    logic [BYTE_W-1:0]   key_a_byte;
    logic [BYTE_W-1:0]   mixed;
    logic [BYTE_W-1:0]   swapped;

    assign cipher  = i_data[BYTE_W-1:0];
    assign count   = i_data[IN_DATA_W-1:BYTE_W];
    assign stepped = sched_step(r_sched);

    assign key_b_byte = i_cfg.key_b[{r_sched.pos_b, 3'b000} +: BYTE_W];
    assign key_a_byte = i_cfg.key_a[{r_sched.pos_a, 3'b000} +: BYTE_W];
    assign mixed      = cipher ^ {1'b0, r_sched.kn} ^ key_b_byte;
    assign swapped    = r_sched.swap ? {mixed[3:0], mixed[7:4]} : mixed;

    always_comb begin
        n_sched = r_sched;
        n_cnt   = r_cnt;
        if (i_cmd.start) begin
            n_sched.kn    = i_cfg.start_kn;
            n_sched.pos_a = '0;
            n_sched.pos_b = POS_B_START;
            n_sched.swap  = 1'b0;
        end else if (i_cmd.decrypt || i_cmd.skip_first || i_cmd.skip_step) begin
            n_sched = stepped;
        end
        if (i_cmd.skip_first) begin
            n_cnt = count - 16'd1;
        end else if (i_cmd.skip_step) begin
            n_cnt = r_cnt - 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sched.kn    <= '0;
            r_sched.pos_a <= '0;
            r_sched.pos_b <= POS_B_START;
            r_sched.swap  <= 1'b0;
            r_cnt         <= '0;
        end else begin
            r_sched <= n_sched;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decrypt) begin
            r_plain <= swapped ^ key_a_byte;
        end
    end

    assign o_sts.count_zero   = (count == '0);
    assign o_sts.count_le_one = (count[COUNT_W-1:1] == '0);
    assign o_sts.remain_one   = (r_cnt == 16'd1);
    assign o_plain            = r_plain;

endmodule

@@ hw/rtl/rkbd_ctrl.sv @@
// ---------------------------------------------------------------------------
// rkbd_ctrl
// Controller: input handshake, skip sequencing and output word valid.
// ---------------------------------------------------------------------------
module rkbd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_in_action,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  rkbd_pkg::t_dp_sts   i_sts,
    output rkbd_pkg::t_dp_cmd   o_cmd
);
    import rkbd_pkg::*;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    logic    accept;
    t_action action;

    assign action = t_action'(i_in_action);
    assign accept = i_in_valid && o_in_ready;

    // A new word may enter when no skip is being stepped and the output register is free or drains now.
    assign o_in_ready = (r_state == ST_IDLE) && i_rst_n && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && action == ACT_SKIP && !i_sts.count_le_one) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (i_sts.remain_one) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (action)
                        ACT_START:   o_cmd.start      = 1'b1;
                        ACT_DECRYPT: o_cmd.decrypt    = 1'b1;
                        ACT_SKIP:    o_cmd.skip_first = !i_sts.count_zero;
                        default: ;
                    endcase
                end
            end
            ST_SKIP: begin
                o_cmd.skip_step = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.decrypt) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ hw/rtl/rolling_key_byte_decryptor_core.sv @@
// A decrypt word shows its plain byte in the cycle after it is accepted.
// Start and decrypt words may follow back to back unless the output stalls; a skip of n
// steps the schedule n times, the single schedule step unit stepping once per cycle.
// Output and input sides are parted by the output register, so a decrypt may
// enter in the cycle the previous result is taken.
// Reset (synchronous, active low) clears keys, key number and flag, sets A to 0, B to 8.
// ---------------------------------------------------------------------------
// rolling_key_byte_decryptor_core
// Rolling key byte decryptor: APB key registers, controller and datapath.
// ---------------------------------------------------------------------------
module rolling_key_byte_decryptor_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // tdata: cipher_byte [7:0], skip_count [23:8]
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [rkbd_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // tuser: action [1:0]
    input  logic [1:0]                         i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // tdata: plain_byte [7:0]
    output logic [rkbd_pkg::BYTE_W-1:0]        o_m_axis_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rkbd_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [rkbd_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [rkbd_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import rkbd_pkg::*;

    t_cfg    cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;

    rkbd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rkbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_action (i_s_axis_tuser),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rkbd_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_cfg   (cfg),
        .i_data  (i_s_axis_tdata),
        .o_sts   (sts),
        .o_plain (o_m_axis_tdata)
    );

endmodule

@@ hw/rtl/rkbd_checker.sv @@
// ---------------------------------------------------------------------------
// rkbd_checker
// Port-level checks on the decryptor, bound to the top level.
// ---------------------------------------------------------------------------
`include "rolling_key_byte_decryptor_core_assert.svh"

module rkbd_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    input  logic                               o_s_axis_tready,
    input  logic [rkbd_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    input  logic [1:0]                         i_s_axis_tuser,
    input  logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    input  logic [rkbd_pkg::BYTE_W-1:0]        o_m_axis_tdata
);
    import rkbd_pkg::*;

    logic in_acc;
    logic in_dec;
    logic in_other;
    logic in_long_skip;
    logic out_wait;

    assign in_acc       = i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
    assign in_dec       = in_acc && (i_s_axis_tuser == ACT_DECRYPT);
    assign in_other     = in_acc && (i_s_axis_tuser != ACT_DECRYPT) && !o_m_axis_tvalid;
    // A skip of two or more keeps the core busy past the accepting cycle.
    assign in_long_skip = in_acc && (i_s_axis_tuser == ACT_SKIP) &&
                          (i_s_axis_tdata[IN_DATA_W-1:BYTE_W+1] != '0);
    assign out_wait     = o_m_axis_tvalid && !i_m_axis_tready;

    `RKBD_ASSERT_NEXT(a_out_hold, out_wait, o_m_axis_tvalid)
    `RKBD_ASSERT_NEXT(a_out_stable, out_wait, $stable(o_m_axis_tdata))
    `RKBD_ASSERT_NEXT(a_decrypt_gives_word, in_dec, o_m_axis_tvalid)
    `RKBD_ASSERT_NEXT(a_no_word_invented, in_other, !o_m_axis_tvalid)
    `RKBD_ASSERT_NEXT(a_long_skip_busy, in_long_skip, !o_s_axis_tready)

endmodule

bind rolling_key_byte_decryptor_core rkbd_checker u_rkbd_checker (.*);

@@ sim/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// Testbench for the rolling key byte decryptor core. It loads keys over the
// register port, streams start, decrypt and skip words with random gaps and
// output stalls, and checks every plain byte against an internal predictor.
// ---------------------------------------------------------------------------
module tb_top;

    import rkbd_pkg::*;

    // The action code with no operation behind it.
    localparam logic [1:0] ACT_NONE     = 2'd3;
    localparam int         STALL_LIMIT  = 300000;
    localparam int         DRAIN_MARGIN = 8;
    localparam int         IDLE_PCT     = 38;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_valid;
    logic                   s_ready;
    logic [IN_DATA_W-1:0]   s_data;
    logic [1:0]             s_user;
    logic                   m_valid;
    logic                   m_ready;
    logic [BYTE_W-1:0]      m_data;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [CFG_ADDR_W-1:0]  paddr;
    logic [CFG_DATA_W-1:0]  pwdata;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    // Predictor copy of the configuration and the key schedule.
    logic [KEY_W-1:0]       key_a;
    logic [KEY_W-1:0]       key_b;
    logic [KN_W-1:0]        start_kn;
    logic [KN_W-1:0]        key_num;
    logic [POS_W-1:0]       pos_a;
    logic [POS_W-1:0]       pos_b;
    logic                   swap_on;

    logic [BYTE_W-1:0]      expected_plain[$];
    logic [BYTE_W-1:0]      want_plain;
    int                     busy_after_last;
    int                     err_cnt;
    int                     idle_cycles;
    bit                     src_steady;
    bit                     snk_steady;
    int                     hold_len;
    int                     hold_req;
    int                     hold_seen;
    int                     hold_cnt;

    rolling_key_byte_decryptor_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [IN_DATA_W-1:0] pack_word(input logic [BYTE_W-1:0] cipher,
                                                       input logic [COUNT_W-1:0] count);
        return {count, cipher};
    endfunction

    function automatic logic [BYTE_W-1:0] key_byte_at(input logic [KEY_W-1:0] k,
                                                      input logic [POS_W-1:0] p);
        return k[p*8 +: 8];
    endfunction

    // One step of the position wrap schedule.
    function automatic void step_schedule();
        int a;
        int b;
        a = int'(pos_a) + 1;
        b = int'(pos_b) + 1;
        if (a <= 15) begin
            if (b > 12) begin
                b       = 0;
                swap_on = ~swap_on;
            end
        end else if (b <= 8) begin
            a       = 0;
            swap_on = ~swap_on;
        end else begin
            key_num = key_num + 7'd2;
            if (swap_on) begin
                swap_on = 1'b0;
                a       = key_num % 7;
                b       = key_num % 12 + 2;
            end else begin
                swap_on = 1'b1;
                a       = key_num % 12 + 3;
                b       = key_num % 7;
            end
        end
        pos_a = a[POS_W-1:0];
        pos_b = b[POS_W-1:0];
    endfunction

    function automatic void predict_word(input logic [1:0] act,
                                         input logic [IN_DATA_W-1:0] data);
        logic [BYTE_W-1:0] d;
        int                n;
        case (act)
            ACT_START: begin
                key_num = start_kn;
                pos_a   = '0;
                pos_b   = POS_B_START;
                swap_on = 1'b0;
            end
            ACT_DECRYPT: begin
                d = data[BYTE_W-1:0] ^ {1'b0, key_num} ^ key_byte_at(key_b, pos_b);
                if (swap_on) begin
                    d = {d[3:0], d[7:4]};
                end
                d = d ^ key_byte_at(key_a, pos_a);
                step_schedule();
                expected_plain.push_back(d);
            end
            ACT_SKIP: begin
                n = int'(data[BYTE_W +: COUNT_W]);
                for (int i = 0; i < n; i++) begin
                    step_schedule();
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Offers one word and returns at the edge where it is taken. The valid
    // line is left high so that back-to-back words follow without a gap.
    task automatic send_word(input logic [1:0] act, input logic [IN_DATA_W-1:0] data);
        while (!src_steady && ($urandom_range(99) < IDLE_PCT)) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= data;
        s_user  <= act;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        predict_word(act, data);
        busy_after_last = (act == ACT_SKIP) ? int'(data[BYTE_W +: COUNT_W]) : 0;
    endtask

    // A skip gives no result, so after the last byte arrives the core may
    // still be stepping through the last skip count.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_plain.size() != 0) @(posedge i_clk);
        repeat (busy_after_last + DRAIN_MARGIN) @(posedge i_clk);
        busy_after_last = 0;
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_KEY_A_LO: key_a[63:0]   = value;
            REG_KEY_A_HI: key_a[127:64] = value;
            REG_KEY_B_LO: key_b[63:0]   = value;
            REG_KEY_B_HI: key_b[127:64] = value;
            REG_START_KN: start_kn      = value[KN_W-1:0];
            default: begin
            end
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_keys(input logic [63:0] a_lo, input logic [63:0] a_hi,
                            input logic [63:0] b_lo, input logic [63:0] b_hi,
                            input logic [KN_W-1:0] kn);
        wait_idle();
        apb_write(REG_KEY_A_LO, a_lo);
        apb_write(REG_KEY_A_HI, a_hi);
        apb_write(REG_KEY_B_LO, b_lo);
        apb_write(REG_KEY_B_HI, b_hi);
        apb_write(REG_START_KN, {{(CFG_DATA_W-KN_W){1'b0}}, kn});
    endtask

    // Keys straight out of reset are all zero.
    task automatic test_reset_state();
        send_word(ACT_DECRYPT, pack_word(8'h00, 16'hFFFF));
        send_word(ACT_DECRYPT, pack_word(8'hFF, 16'h0000));
        // A zero skip must leave the schedule where it is.
        send_word(ACT_SKIP, pack_word(8'hFF, 16'd0));
        // The unused action code is dropped without a trace.
        send_word(ACT_NONE, pack_word(BYTE_W'($urandom), COUNT_W'($urandom)));
        send_word(ACT_SKIP, pack_word(8'h00, 16'd1));
        send_word(ACT_DECRYPT, pack_word(8'h5A, 16'hA5A5));
        send_word(ACT_START, pack_word(8'hFF, 16'hFFFF));
        send_word(ACT_DECRYPT, pack_word(8'hA5, 16'h5A5A));
    endtask

    task automatic test_extreme_keys();
        set_keys('1, '1, '1, '1, 7'h7F);
        send_word(ACT_START, pack_word(8'h00, 16'h0000));
        send_word(ACT_DECRYPT, pack_word(8'h00, 16'h0000));
        send_word(ACT_DECRYPT, pack_word(8'hFF, 16'hFFFF));
        send_word(ACT_SKIP, pack_word(8'h00, 16'hFFFF));
        send_word(ACT_DECRYPT, pack_word(8'h3C, 16'h0F0F));
        send_word(ACT_SKIP, pack_word(8'hFF, 16'd12));
        send_word(ACT_DECRYPT, pack_word(8'hC3, 16'hF0F0));
        send_word(ACT_NONE, '1);
        send_word(ACT_DECRYPT, pack_word(8'h81, 16'h8001));
    endtask

    // The sink holds off while the source keeps pushing, so the output
    // register fills and the core must stall its input.
    task automatic test_output_stall();
        set_keys({$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom}, KN_W'($urandom));
        send_word(ACT_START, pack_word(BYTE_W'($urandom), COUNT_W'($urandom)));
        hold_len   = 300;
        hold_req   = hold_req + 1;
        src_steady = 1'b1;
        for (int i = 0; i < 40; i++) begin
            send_word(ACT_DECRYPT, IN_DATA_W'($urandom));
        end
        src_steady = 1'b0;
    endtask

    task automatic test_random_stream();
        logic [1:0]           act;
        logic [IN_DATA_W-1:0] data;
        int                   r;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_keys('0, '0, '0, '0, 7'h00);
                1: set_keys('1, '1, '1, '1, 7'h7F);
                default: set_keys({$urandom, $urandom}, {$urandom, $urandom},
                                  {$urandom, $urandom}, {$urandom, $urandom},
                                  KN_W'($urandom));
            endcase
            src_steady = (phase == 3);
            snk_steady = (phase == 3);
            send_word(ACT_START, IN_DATA_W'($urandom));
            for (int i = 0; i < 330; i++) begin
                data = IN_DATA_W'($urandom);
                r    = $urandom_range(99);
                if (r < 7) begin
                    act = ACT_START;
                end else if (r < 80) begin
                    act = ACT_DECRYPT;
                end else if (r < 93) begin
                    act = ACT_SKIP;
                    // Mostly short skips, now and then a long one.
                    data[BYTE_W +: COUNT_W] = ($urandom_range(299) == 0) ?
                        COUNT_W'($urandom_range(65535, 256)) :
                        COUNT_W'($urandom_range(40));
                end else begin
                    act = ACT_NONE;
                end
                send_word(act, data);
            end
        end
        src_steady = 1'b0;
        snk_steady = 1'b0;
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) begin
            if (expected_plain.size() == 0) begin
                $error("plain_byte: expected none, actual %02h", m_data);
                err_cnt++;
            end else begin
                want_plain = expected_plain.pop_front();
                if (m_data !== want_plain) begin
                    $error("plain_byte: expected %02h, actual %02h", want_plain, m_data);
                    err_cnt++;
                end
            end
        end
    end

    // Sink ready, with random stalls and the requested hold-off.
    always @(posedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_cnt  = hold_len;
        end
        if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= snk_steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("rolling_key_byte_decryptor_core: mismatch");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        s_valid         = 1'b0;
        s_data          = '0;
        s_user          = '0;
        m_ready         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        key_a           = '0;
        key_b           = '0;
        start_kn        = '0;
        key_num         = '0;
        pos_a           = '0;
        pos_b           = POS_B_START;
        swap_on         = 1'b0;
        busy_after_last = 0;
        err_cnt         = 0;
        idle_cycles     = 0;
        src_steady      = 1'b0;
        snk_steady      = 1'b0;
        hold_len        = 0;
        hold_req        = 0;
        hold_seen       = 0;
        hold_cnt        = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_extreme_keys();
        test_output_stall();
        test_random_stream();
        wait_idle();
        if (err_cnt == 0 && expected_plain.size() == 0) begin
            $display("rolling_key_byte_decryptor_core: match");
        end else begin
            $display("rolling_key_byte_decryptor_core: mismatch");
        end
        $finish;
    end

endmodule
